[design/lkc_pkg.sv]
// shared types and constants of the keyed lru cache
package lkc_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W         = $clog2(CACHE_ENTRIES);
  localparam int AGE_W         = IDX_W;
  localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);

  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_INSERT   = 1'b1;

  typedef struct packed {
    logic        insert;
    logic [31:0] key;
    logic [31:0] payload;
  } op_t;

endpackage

[design/lkc_if.sv]
// request and response channel interfaces of the keyed lru cache
interface lkc_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] key;
  logic [31:0] payload;

  modport source (output valid, opcode, key, payload, input ready);
  modport sink   (input valid, opcode, key, payload, output ready);
endinterface

interface lkc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] read_payload;
  logic        evicted;
  logic [31:0] evicted_key;

  modport source (output valid, hit, read_payload, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_payload, evicted, evicted_key, output ready);
endinterface

[design/lkc_front.sv]
// front end: accepts request items, decodes them and queues them for the back end
module lkc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  lkc_req_if.sink       req,
  output lkc_pkg::op_t  op_o,
  output logic          op_valid_o,
  input  logic          op_ready_i
);
  import lkc_pkg::*;

  op_t               queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push;
  logic              pop;
  op_t               op_dec;

  assign req.ready  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign op_valid_o = (cnt_q != '0);
  assign op_o       = queue_q[rd_ptr_q];
  assign push       = req.valid && req.ready;
  assign pop        = op_valid_o && op_ready_i;

  // classify the item
  always_comb begin
    op_dec.insert  = (req.opcode == OP_INSERT);
    op_dec.key     = req.key;
    op_dec.payload = req.payload;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= op_dec;
    end
  end

endmodule

[design/lkc_back.sv]
// back end: tag scan, lru victim search, slot update and response register
module lkc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lkc_pkg::op_t  op_i,
  input  logic          op_valid_i,
  output logic          op_ready_o,
  lkc_rsp_if.source     rsp
);
  import lkc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_q;
  op_t              op_q;
  logic [CNT_W-1:0] scan_q;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;

  logic             found_q;
  logic [IDX_W-1:0] found_idx_q;
  logic [AGE_W-1:0] found_age_q;
  logic [31:0]      found_pay_q;
  logic             free_vld_q;
  logic [IDX_W-1:0] free_idx_q;
  logic             vic_vld_q;
  logic [IDX_W-1:0] vic_idx_q;
  logic [AGE_W-1:0] vic_age_q;
  logic [31:0]      vic_key_q;

  logic             valid_q [CACHE_ENTRIES];
  logic [AGE_W-1:0] age_q   [CACHE_ENTRIES];
  logic [CNT_W-1:0] fill_q;

  logic [31:0]      key_mem [CACHE_ENTRIES];
  logic [31:0]      pay_mem [CACHE_ENTRIES];
  logic [31:0]      key_rd_q;
  logic [31:0]      pay_rd_q;

  logic             rsp_valid_q;
  logic             rsp_hit_q;
  logic [31:0]      rsp_pay_q;
  logic             rsp_evicted_q;
  logic [31:0]      rsp_evkey_q;

  logic             issue;
  logic [IDX_W-1:0] rd_addr;
  logic             cur_valid;
  logic [AGE_W-1:0] cur_age;
  logic             key_eq;
  logic             full;
  logic             commit;
  logic             promote_en;
  logic             all_older;
  logic [AGE_W-1:0] old_age;
  logic [IDX_W-1:0] tgt_idx;
  logic             key_we;
  logic             pay_we;
  logic             new_slot;

  assign op_ready_o = (state_q == ST_IDLE);
  assign issue      = (state_q == ST_SCAN) && (scan_q != CNT_W'(CACHE_ENTRIES));
  assign rd_addr    = scan_q[IDX_W-1:0];
  assign cur_valid  = valid_q[cmp_idx_q];
  assign cur_age    = age_q[cmp_idx_q];
  assign key_eq     = (key_rd_q == op_q.key);
  assign full       = (fill_q == CNT_W'(CACHE_ENTRIES));
  assign commit     = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

  // slot to update and how the ages move
  always_comb begin
    promote_en = commit && (found_q || op_q.insert);
    all_older  = !found_q && !full;
    old_age    = found_q ? found_age_q : vic_age_q;
    tgt_idx    = found_q ? found_idx_q : (full ? vic_idx_q : free_idx_q);
    pay_we     = commit && op_q.insert;
    key_we     = commit && op_q.insert && !found_q;
    new_slot   = key_we && !full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      free_vld_q  <= 1'b0;
      vic_vld_q   <= 1'b0;
      fill_q      <= '0;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
        age_q[i]   <= '0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (op_valid_i) begin
            scan_q     <= '0;
            cmp_vld_q  <= 1'b0;
            found_q    <= 1'b0;
            free_vld_q <= 1'b0;
            vic_vld_q  <= 1'b0;
            state_q    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            scan_q    <= scan_q + 1'b1;
            cmp_vld_q <= 1'b1;
          end else begin
            cmp_vld_q <= 1'b0;
            state_q   <= ST_DONE;
          end
          if (cmp_vld_q) begin
            if (cur_valid) begin
              if (!found_q && key_eq) begin
                found_q <= 1'b1;
              end
              if (!vic_vld_q || cur_age > vic_age_q) begin
                vic_vld_q <= 1'b1;
              end
            end else if (!free_vld_q) begin
              free_vld_q <= 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (commit) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (promote_en) begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          if (IDX_W'(i) == tgt_idx) begin
            age_q[i] <= '0;
          end else if (valid_q[i] && (all_older || age_q[i] < old_age)) begin
            age_q[i] <= age_q[i] + 1'b1;
          end
        end
      end
      if (new_slot) begin
        valid_q[tgt_idx] <= 1'b1;
        fill_q           <= fill_q + 1'b1;
      end

      if (commit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // payload side of the scan and the response
  always_ff @(posedge clk_i) begin
    if (op_valid_i && op_ready_o) begin
      op_q <= op_i;
    end
    if (issue) begin
      cmp_idx_q <= rd_addr;
    end
    if ((state_q == ST_SCAN) && cmp_vld_q) begin
      if (cur_valid) begin
        if (!found_q && key_eq) begin
          found_idx_q <= cmp_idx_q;
          found_age_q <= cur_age;
          found_pay_q <= pay_rd_q;
        end
        if (!vic_vld_q || cur_age > vic_age_q) begin
          vic_idx_q <= cmp_idx_q;
          vic_age_q <= cur_age;
          vic_key_q <= key_rd_q;
        end
      end else if (!free_vld_q) begin
        free_idx_q <= cmp_idx_q;
      end
    end
    if (commit) begin
      rsp_hit_q     <= found_q;
      rsp_pay_q     <= (found_q && !op_q.insert) ? found_pay_q : 32'd0;
      rsp_evicted_q <= !found_q && op_q.insert && full;
      rsp_evkey_q   <= (!found_q && op_q.insert && full) ? vic_key_q : 32'd0;
    end
  end

  // tag and payload memories
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[tgt_idx] <= op_q.key;
    end
    if (issue) begin
      key_rd_q <= key_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[tgt_idx] <= op_q.payload;
    end
    if (issue) begin
      pay_rd_q <= pay_mem[rd_addr];
    end
  end

  assign rsp.valid        = rsp_valid_q;
  assign rsp.hit          = rsp_hit_q;
  assign rsp.read_payload = rsp_pay_q;
  assign rsp.evicted      = rsp_evicted_q;
  assign rsp.evicted_key  = rsp_evkey_q;

endmodule

[design/lru_keyed_cache.sv]
// top level of the fully associative keyed cache with lru replacement
// usage:
//   req carries one operation per item: opcode (0 lookup, 1 insert or update),
//   key and payload; it is taken when valid and ready are both high
//   rsp returns exactly one item per request, in order: hit, read_payload,
//   evicted and evicted_key, held until the receiver takes it
//   a two-item queue sits between the request side and the execution engine,
//   so requests keep being taken while the engine or the receiver is busy
//   each operation passes through the engine in order: it fetches the item,
//   reads tag and payload memory entry by entry while tracking the match,
//   the free slot and the lru victim, does the last compare, then updates
//   the slot and loads the response
//   the engine takes a new item only once it is through with the last one
//   reset clears all valid marks, ages, the fill count and the queue at once;
//   tag and payload memories are not cleared and are only read behind valid
//   if the receiver stalls, the finished response waits in the output
//   register, the engine holds its result and the queue fills, then ready drops
module lru_keyed_cache (
  input  logic      clk_i,
  input  logic      rst_ni,
  lkc_req_if.sink   req,
  lkc_rsp_if.source rsp
);
  import lkc_pkg::*;

  op_t  op;
  logic op_valid;
  logic op_ready;

  lkc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req),
    .op_o       (op),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready)
  );

  lkc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .op_valid_i (op_valid),
    .op_ready_o (op_ready),
    .rsp        (rsp)
  );

endmodule
